[sv/udp_source_flood_detector_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the UDP source flood detector
// Shared by the checker; each macro expands to one labeled concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef UDP_SOURCE_FLOOD_DETECTOR_DEFINES_SVH
`define UDP_SOURCE_FLOOD_DETECTOR_DEFINES_SVH

// same-cycle implication, off during reset
`define FSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flood detector check failed");

// next-cycle implication, off during reset
`define FSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flood detector check failed");

`endif

[sv/fsd_pkg.sv]
// ---------------------------------------------------------------------------
// fsd_pkg
// Types and constants of the UDP source flood detector.
// ---------------------------------------------------------------------------
package fsd_pkg;

  localparam int TABLE_ENTRIES   = 256;
  localparam int IDX_W           = $clog2(TABLE_ENTRIES);
  localparam int OCC_W           = $clog2(TABLE_ENTRIES + 1);
  localparam int REPORT_INTERVAL = 200;
  localparam int RES_W           = $clog2(REPORT_INTERVAL + 1);

  localparam logic [15:0] MIN_FRAME_BYTES = 16'd42;
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;

  localparam logic [31:0] THRESHOLD_RESET  = 32'd2000;
  localparam logic [6:0]  CONFIDENCE_RESET = 7'd70;

  localparam int          CFG_IDX_W      = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIDENCE = 8'd1;

  // front queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] destination_port;
  } frame_t;

  typedef struct packed {
    logic        event_valid;
    logic [31:0] event_source;
    logic [31:0] event_count;
    logic [15:0] event_port;
    logic [6:0]  event_certainty;
    logic        counted;
    logic        table_full_miss;
  } result_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic        qualify;
    logic [31:0] source_address;
    logic [15:0] destination_port;
  } job_t;

endpackage

[sv/udp_source_flood_detector.sv]
// A frame passes the front queue, then a read and a check state per entry scanned.
// A frame that does not qualify gets its result from the idle state; a known source
// at slot k after slots 0 to k are scanned, a new source after every used slot.
// Throughput is set by the sequential table scan over one read port and the result pop.
// Reset: synchronous, clears queue, fill count and result valid; registers to defaults.
// ---------------------------------------------------------------------------
// udp_source_flood_detector
// Per-source UDP packet counter that flags flood events at set intervals.
// ---------------------------------------------------------------------------
module udp_source_flood_detector (
  input  logic                           clk,
  input  logic                           rst,
  // frame input, queue style
  input  logic                           push,
  output logic                           full,
  input  fsd_pkg::frame_t                frame,
  // results, queue style
  output logic                           empty,
  input  logic                           pop,
  output fsd_pkg::result_t               result,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic          job_avail;
  logic          job_take;
  fsd_pkg::job_t job;
  logic          res_valid;
  logic [31:0]   flood_threshold;
  logic [6:0]    event_confidence;

  // config is always taken; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flood_threshold  <= fsd_pkg::THRESHOLD_RESET;
      event_confidence <= fsd_pkg::CONFIDENCE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fsd_pkg::CFG_THRESHOLD:  flood_threshold  <= cfg_data;
        fsd_pkg::CFG_CONFIDENCE: event_confidence <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // front: classify and queue so input transfers continue while the engine scans
  fsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .frame     (frame),
    .job_avail (job_avail),
    .job_take  (job_take),
    .job       (job)
  );

  // back: table scan, count update and result register
  fsd_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .job_avail        (job_avail),
    .job_take         (job_take),
    .job              (job),
    .flood_threshold  (flood_threshold),
    .event_confidence (event_confidence),
    .res_valid        (res_valid),
    .res_take         (pop),
    .res              (result)
  );

  assign empty = !res_valid;

endmodule

[sv/fsd_front.sv]
// ---------------------------------------------------------------------------
// fsd_front
// Classifies incoming frames and queues them for the table engine.
// ---------------------------------------------------------------------------
module fsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  fsd_pkg::frame_t frame,
  output logic            job_avail,
  input  logic            job_take,
  output fsd_pkg::job_t   job
);

  fsd_pkg::job_t                    q [fsd_pkg::QDEPTH];
  logic [fsd_pkg::QPTR_W-1:0]       wptr;
  logic [fsd_pkg::QPTR_W-1:0]       rptr;
  logic [fsd_pkg::QCNT_W-1:0]       count;
  fsd_pkg::job_t                    cls;
  logic                             wr;
  logic                             rd;

  always_comb begin
    cls.qualify = (frame.frame_length >= fsd_pkg::MIN_FRAME_BYTES) &&
                  (frame.ether_type == fsd_pkg::ETHERTYPE_IPV4) &&
                  (frame.ip_protocol == fsd_pkg::PROTO_UDP);
    cls.source_address   = frame.source_address;
    cls.destination_port = frame.destination_port;
  end

  assign full      = (count == fsd_pkg::QCNT_W'(fsd_pkg::QDEPTH));
  assign job_avail = (count != '0);
  assign job       = q[rptr];
  assign wr        = push && !full;
  assign rd        = job_take && job_avail;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == fsd_pkg::QPTR_W'(fsd_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == fsd_pkg::QPTR_W'(fsd_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + fsd_pkg::QCNT_W'(wr) - fsd_pkg::QCNT_W'(rd);
    end
  end

endmodule

[sv/fsd_engine.sv]
// ---------------------------------------------------------------------------
// fsd_engine
// Scans the source table, counts or inserts, and holds the result.
// ---------------------------------------------------------------------------
module fsd_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_avail,
  output logic             job_take,
  input  fsd_pkg::job_t    job,
  input  logic [31:0]      flood_threshold,
  input  logic [6:0]       event_confidence,
  output logic             res_valid,
  input  logic             res_take,
  output fsd_pkg::result_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  localparam logic [fsd_pkg::RES_W-1:0] RES_ONE  =
    fsd_pkg::RES_W'(1 % fsd_pkg::REPORT_INTERVAL);
  localparam logic [fsd_pkg::RES_W-1:0] RES_LAST =
    fsd_pkg::RES_W'(fsd_pkg::REPORT_INTERVAL - 1);

  logic [31:0]               key_mem [fsd_pkg::TABLE_ENTRIES];
  logic [31:0]               cnt_mem [fsd_pkg::TABLE_ENTRIES];
  logic [fsd_pkg::RES_W-1:0] res_mem [fsd_pkg::TABLE_ENTRIES];

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [fsd_pkg::IDX_W-1:0] idx;
  logic [fsd_pkg::OCC_W-1:0] occupancy;
  fsd_pkg::job_t             cur;

  logic [31:0]               rd_key;
  logic [31:0]               rd_cnt;
  logic [fsd_pkg::RES_W-1:0] rd_res;

  logic                      wr_en;
  logic [fsd_pkg::IDX_W-1:0] wr_addr;
  logic [31:0]               wr_cnt;
  logic [fsd_pkg::RES_W-1:0] wr_res;

  logic                      hit;
  logic                      last;
  logic                      room;
  logic                      sat;
  logic [31:0]               new_cnt;
  logic [fsd_pkg::RES_W-1:0] new_res;
  logic                      produce;
  fsd_pkg::result_t          res_next;

  always_ff @(posedge clk) begin
    rd_key <= key_mem[idx];
    rd_cnt <= cnt_mem[idx];
    rd_res <= res_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= cur.source_address;
      cnt_mem[wr_addr] <= wr_cnt;
      res_mem[wr_addr] <= wr_res;
    end
  end

  always_comb begin
    hit     = (rd_key == cur.source_address);
    last    = ({1'b0, idx} + 1'b1 == occupancy);
    room    = (occupancy != fsd_pkg::OCC_W'(fsd_pkg::TABLE_ENTRIES));
    sat     = (rd_cnt == 32'hFFFF_FFFF);
    new_cnt = sat ? rd_cnt : rd_cnt + 32'd1;
    new_res = sat ? rd_res : ((rd_res == RES_LAST) ? '0 : rd_res + 1'b1);

    state_next = state;
    job_take   = 1'b0;
    produce    = 1'b0;
    res_next   = '0;
    wr_en      = 1'b0;
    wr_addr    = occupancy[fsd_pkg::IDX_W-1:0];
    wr_cnt     = 32'd1;
    wr_res     = RES_ONE;

    case (state)
      S_IDLE: begin
        if (job_avail && !res_valid) begin
          job_take = 1'b1;
          if (job.qualify) begin
            state_next = S_READ;
          end else begin
            produce = 1'b1;
          end
        end
      end
      S_READ: begin
        if (occupancy == '0) begin
          // empty table: insert straight away
          wr_en            = 1'b1;
          res_next.counted = 1'b1;
          produce          = 1'b1;
          state_next       = S_IDLE;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          wr_en            = 1'b1;
          wr_addr          = idx;
          wr_cnt           = new_cnt;
          wr_res           = new_res;
          res_next.counted = 1'b1;
          if ((new_cnt > flood_threshold) && (new_res == '0)) begin
            res_next.event_valid     = 1'b1;
            res_next.event_source    = cur.source_address;
            res_next.event_count     = new_cnt;
            res_next.event_port      = cur.destination_port;
            res_next.event_certainty = event_confidence;
          end
          produce    = 1'b1;
          state_next = S_IDLE;
        end else if (last) begin
          if (room) begin
            wr_en            = 1'b1;
            res_next.counted = 1'b1;
          end else begin
            res_next.table_full_miss = 1'b1;
          end
          produce    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
    if (produce) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      occupancy <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (job_take) begin
        idx <= '0;
      end else if (state == S_CHECK && !hit && !last) begin
        idx <= idx + 1'b1;
      end
      if (wr_en && wr_addr == occupancy[fsd_pkg::IDX_W-1:0] && !(state == S_CHECK && hit)) begin
        occupancy <= occupancy + 1'b1;
      end
      if (produce) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/fsd_checker.sv]
// ---------------------------------------------------------------------------
// fsd_checker
// Port-level checks on the flood detector results.
// ---------------------------------------------------------------------------
`include "udp_source_flood_detector_defines.svh"

module fsd_checker (
  input logic             clk,
  input logic             rst,
  input logic             empty,
  input logic             pop,
  input fsd_pkg::result_t result
);

  `FSD_ASSERT_IMP(a_quiet_fields, !empty && !result.event_valid, result.event_count == 32'd0 && result.event_source == 32'd0 && result.event_port == 16'd0 && result.event_certainty == 7'd0)
  `FSD_ASSERT_IMP(a_event_counted, !empty && result.event_valid, result.counted && result.event_count != 32'd0)
  `FSD_ASSERT_IMP(a_count_or_miss, !empty, !(result.counted && result.table_full_miss))
  `FSD_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(result))

endmodule

bind udp_source_flood_detector fsd_checker u_fsd_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

[tb/sv/udp_source_flood_detector_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// udp_source_flood_detector_tb
// Drives header summaries through the flood detector and compares every
// result with a cycle-free software copy of the source table. Covers
// non-qualifying frames, inserts, increments, flood events, several
// thresholds and confidences, ignored register writes and a full table.
// ---------------------------------------------------------------------------
module udp_source_flood_detector_tb;

  localparam int WATCHDOG_LIMIT = 20000;  // well above the worst full-table scan
  localparam int SETTLE_CYCLES  = 600;    // one full table scan plus margin
  localparam logic [fsd_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = fsd_pkg::CFG_IDX_W'(5);

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  fsd_pkg::frame_t               frame = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  fsd_pkg::result_t              result;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fsd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;

  udp_source_flood_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .frame     (frame),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---- shadow of the source table and registers ----
  logic [31:0] tbl_key   [fsd_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_count [fsd_pkg::TABLE_ENTRIES];
  logic        tbl_used  [fsd_pkg::TABLE_ENTRIES];
  int          tbl_fill;
  logic [31:0] thresh_reg;
  logic [6:0]  conf_reg;

  fsd_pkg::frame_t  frame_q[$];     // headers waiting to be sent
  fsd_pkg::result_t verdict_q[$];   // verdicts owed by the block
  int      sender_idle, receiver_idle;
  int      mismatches, frames_sent, verdicts_seen, flood_events, full_misses;
  int      stall_cycles;
  logic [31:0] hot_src[4];

  // Table update for one accepted header; returns the verdict it owes.
  function automatic fsd_pkg::result_t classify_frame(fsd_pkg::frame_t f);
    fsd_pkg::result_t r;
    int      slot;
    logic [31:0] c;
    r = '0;
    slot = -1;
    if (f.frame_length < fsd_pkg::MIN_FRAME_BYTES || f.ether_type != fsd_pkg::ETHERTYPE_IPV4 ||
        f.ip_protocol != fsd_pkg::PROTO_UDP)
      return r;
    for (int i = 0; i < fsd_pkg::TABLE_ENTRIES; i++)
      if (slot < 0 && tbl_used[i] && tbl_key[i] == f.source_address) slot = i;
    if (slot >= 0) begin
      c = tbl_count[slot];
      if (c != 32'hFFFF_FFFF) c = c + 32'd1;   // saturate
      tbl_count[slot] = c;
      r.counted = 1'b1;
      if (c > thresh_reg && (c % fsd_pkg::REPORT_INTERVAL) == 0) begin
        r.event_valid     = 1'b1;
        r.event_source    = f.source_address;
        r.event_count     = c;
        r.event_port      = f.destination_port;
        r.event_certainty = conf_reg;
      end
    end else if (tbl_fill < fsd_pkg::TABLE_ENTRIES) begin
      tbl_key[tbl_fill]   = f.source_address;
      tbl_count[tbl_fill] = 32'd1;
      tbl_used[tbl_fill]  = 1'b1;
      tbl_fill++;
      r.counted = 1'b1;
    end else begin
      r.table_full_miss = 1'b1;
    end
    return r;
  endfunction

  // Qualifying header from a given source, random everything else.
  function automatic fsd_pkg::frame_t udp_frame(logic [31:0] src);
    fsd_pkg::frame_t f;
    f.frame_length     = 16'($urandom_range(42, 65535));
    f.ether_type       = fsd_pkg::ETHERTYPE_IPV4;
    f.ip_protocol      = fsd_pkg::PROTO_UDP;
    f.source_address   = src;
    f.destination_port = 16'($urandom);
    return f;
  endfunction

  // Noise: fully random, or a UDP header with one field broken.
  function automatic fsd_pkg::frame_t noise_frame(logic [31:0] src);
    fsd_pkg::frame_t f;
    f = udp_frame(src);
    case ($urandom_range(0, 3))
      0: f.frame_length = 16'($urandom_range(0, 41));
      1: f.ether_type   = 16'($urandom) | 16'h8000;   // never IPv4
      2: f.ip_protocol  = fsd_pkg::PROTO_UDP ^ 8'(1 << $urandom_range(0, 7));
      default: begin
        f.frame_length = 16'($urandom);
        f.ether_type   = 16'($urandom);
        f.ip_protocol  = 8'($urandom);
      end
    endcase
    return f;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
    mismatches++;
  endtask

  // ---- driver: one transfer per edge where push && !full ----
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        verdict_q.push_back(classify_frame(frame));
        frames_sent++;
      end
      if (push && full) begin
        // hold the stalled header
      end else if (frame_q.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
        frame <= frame_q.pop_front();
        push  <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---- monitor: check each verdict against the oldest owed one ----
  always @(posedge clk) begin
    fsd_pkg::result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $display("unexpected verdict at %0t", $realtime);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (result.event_valid != want.event_valid)
            report_mismatch("event_valid", result.event_valid, want.event_valid);
          if (result.event_source != want.event_source)
            report_mismatch("event_source", result.event_source, want.event_source);
          if (result.event_count != want.event_count)
            report_mismatch("event_count", result.event_count, want.event_count);
          if (result.event_port != want.event_port)
            report_mismatch("event_port", result.event_port, want.event_port);
          if (result.event_certainty != want.event_certainty)
            report_mismatch("event_certainty", result.event_certainty,
                            want.event_certainty);
          if (result.counted != want.counted)
            report_mismatch("counted", result.counted, want.counted);
          if (result.table_full_miss != want.table_full_miss)
            report_mismatch("table_full_miss", result.table_full_miss,
                            want.table_full_miss);
          if (want.event_valid) flood_events++;
          if (want.table_full_miss) full_misses++;
        end
      end
      pop <= ($urandom_range(0, 99) >= receiver_idle);
    end
  end

  // ---- watchdog: cycles with no transfer on any channel ----
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d verdicts owed", verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Register write; only issued while the block is idle.
  task automatic write_reg(logic [fsd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fsd_pkg::CFG_THRESHOLD) thresh_reg = val;
    else if (idx == fsd_pkg::CFG_CONFIDENCE) conf_reg = val[6:0];
  endtask

  // Sender holds off until every owed verdict is back, then the scan settles.
  task automatic drain();
    do @(negedge clk); while (frame_q.size() > 0 || push || verdict_q.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    mismatches = 0; frames_sent = 0; verdicts_seen = 0;
    flood_events = 0; full_misses = 0; stall_cycles = 0;
    tbl_fill = 0;
    thresh_reg = fsd_pkg::THRESHOLD_RESET;
    conf_reg   = fsd_pkg::CONFIDENCE_RESET;
    for (int i = 0; i < fsd_pkg::TABLE_ENTRIES; i++) begin
      tbl_used[i] = 1'b0; tbl_key[i] = '0; tbl_count[i] = '0;
    end
    for (int i = 0; i < 4; i++) hot_src[i] = $urandom;
    sender_idle = 32; receiver_idle = 58;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: qualify boundaries and field extremes
    frame_q.push_back('{16'd41, fsd_pkg::ETHERTYPE_IPV4, fsd_pkg::PROTO_UDP, 32'h0, 16'h0});
    frame_q.push_back('{16'd42, fsd_pkg::ETHERTYPE_IPV4, fsd_pkg::PROTO_UDP, 32'h0, 16'h0});
    frame_q.push_back('{16'hFFFF, fsd_pkg::ETHERTYPE_IPV4, fsd_pkg::PROTO_UDP, 32'h0,
                        16'hFFFF});
    frame_q.push_back('{16'hFFFF, fsd_pkg::ETHERTYPE_IPV4, fsd_pkg::PROTO_UDP, 32'hFFFF_FFFF,
                        16'hFFFF});
    frame_q.push_back('{16'h0, 16'h0, 8'h0, 32'h0, 16'h0});
    frame_q.push_back('{16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF});
    frame_q.push_back('{16'd100, 16'h0801, fsd_pkg::PROTO_UDP, 32'h0, 16'd53});
    frame_q.push_back('{16'd100, fsd_pkg::ETHERTYPE_IPV4, 8'd6, 32'h0, 16'd53});
    frame_q.push_back('{16'd100, 16'h86DD, fsd_pkg::PROTO_UDP, 32'hFFFF_FFFF, 16'd53});
    for (int i = 0; i < 4; i++) frame_q.push_back(udp_frame(hot_src[i]));
    for (int i = 0; i < 6; i++)
      frame_q.push_back($urandom_range(0, 99) < 70 ? udp_frame(hot_src[$urandom_range(0, 3)])
                                                   : noise_frame($urandom));
    drain();

    // zero threshold: one hot source crosses a report multiple
    write_reg(fsd_pkg::CFG_THRESHOLD, 32'd0);
    write_reg(fsd_pkg::CFG_CONFIDENCE, 32'hFFFF_FFFF);   // masks to 127, above 100
    write_reg(CFG_UNMAPPED, 32'd12345);                  // unmapped, ignored
    sender_idle = 58; receiver_idle = 32;
    for (int i = 0; i < 210; i++)
      frame_q.push_back((i % 21) == 20 ? noise_frame(hot_src[1]) : udp_frame(hot_src[0]));
    drain();

    // fill the table with fresh sources, then run into full misses
    write_reg(fsd_pkg::CFG_THRESHOLD, 32'd199);
    write_reg(fsd_pkg::CFG_CONFIDENCE, 32'd100);
    sender_idle = 0; receiver_idle = 0;
    for (int i = 0; i < fsd_pkg::TABLE_ENTRIES - 4; i++) frame_q.push_back(udp_frame($urandom));
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 2))
        0: frame_q.push_back(udp_frame($urandom));
        1: frame_q.push_back(udp_frame(hot_src[$urandom_range(0, 3)]));
        default: frame_q.push_back(noise_frame($urandom));
      endcase
    end
    drain();

    // maximum threshold: no event can fire
    write_reg(fsd_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(fsd_pkg::CFG_CONFIDENCE, 32'd0);
    for (int i = 0; i < 6; i++) frame_q.push_back(udp_frame(hot_src[0]));
    drain();

    if (verdict_q.size() != 0) begin
      $display("%0d verdicts never arrived", verdict_q.size());
      mismatches++;
    end
    $display("covered %0d headers, %0d verdicts, %0d flood events, %0d full-table misses",
             frames_sent, verdicts_seen, flood_events, full_misses);
    $display("table ended with %0d of %0d slots in use", tbl_fill, fsd_pkg::TABLE_ENTRIES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/fsd_pkg.sv
sv/fsd_front.sv
sv/fsd_engine.sv
sv/udp_source_flood_detector.sv
sv/fsd_checker.sv
tb/sv/udp_source_flood_detector_tb.sv
